// ===== hw/rtl/key_debounce_click_press_detector_unit_defines.svh =====
`ifndef KEY_DEBOUNCE_CLICK_PRESS_DETECTOR_UNIT_DEFINES_SVH
`define KEY_DEBOUNCE_CLICK_PRESS_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`ifndef NO_ASSERTIONS
`define KDCP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define KDCP_ASSERT_NOW(lbl, ante, cons)
`endif

// Next-cycle implication, checked outside reset.
`ifndef NO_ASSERTIONS
`define KDCP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define KDCP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/kdcp_pkg.sv =====
`default_nettype none

package kdcp_pkg;

    localparam int KEY_W      = 24;
    localparam int KEY_BITS   = 24;
    localparam int TIMER_BITS = 16;
    localparam int PERIOD_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int MAX_EVENTS = 3;
    localparam int EV_CNT_W   = 2;

    localparam logic [KEY_W-1:0] KEY_MASK =
        KEY_W'((64'd1 << KEY_BITS) - 64'd1);
    localparam logic [TIMER_BITS-1:0] CNT_MAX = {TIMER_BITS{1'b1}};

    localparam logic [KEY_W-1:0]    IDLE_PATTERN_RST = 24'hFFFFFF;
    localparam logic [PERIOD_W-1:0] PRESS_TICKS_RST  = 16'd100;
    localparam logic [PERIOD_W-1:0] DOUBLE_TICKS_RST = 16'd30;
    localparam logic [PERIOD_W-1:0] REPEAT_TICKS_RST = 16'd10;

    localparam logic [CFG_IDX_W-1:0] REG_IDLE_PATTERN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_TICKS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_TICKS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_TICKS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_ENABLE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_ENABLE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_ENABLE = 3'd6;

    typedef enum logic [1:0] {
        EV_UP     = 2'd0,
        EV_DOWN   = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_PUSH   = 2'd3
    } t_event_kind;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_WAIT   = 2'd1,
        PH_REPEAT = 2'd2
    } t_press_phase;

    // Saturating tick count and its expiry against a period.
    typedef struct packed {
        logic [TIMER_BITS-1:0] count;
        logic                  expired;
    } t_tick;

    function automatic t_tick tick_count(input logic [TIMER_BITS-1:0] cnt,
                                         input logic [PERIOD_W-1:0]   period);
        t_tick res;
        res.count   = (cnt == CNT_MAX) ? cnt : cnt + TIMER_BITS'(1);
        res.expired = (33'(res.count) >= 33'(period)) || (res.count == CNT_MAX);
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/key_debounce_click_press_detector_unit.sv =====
// Channel   Direction  Handshake                   Payload
// in        sink       i_in_valid / o_in_stall     i_raw_keys
// out       source     o_out_valid / i_out_stall   o_event_kind, o_key_mask, o_last_of_tick
// cfg       sink       i_cfg_we                    i_cfg_index, i_cfg_data
//
// One scan tick waits in the input register, where the debounce
// and timer logic works on it; its 0 to 3 events then leave one per cycle
// from the event register while i_out_stall is low.
// A new tick enters every cycle while each tick yields at most one event and the output is not stalled.
// Reset is synchronous and active low; there is no clearing pass.
// The input register waits while the event register still holds more than
// the item about to leave.
`default_nettype none

module key_debounce_click_press_detector_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [kdcp_pkg::KEY_W-1:0]          i_raw_keys,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [1:0]                               o_event_kind,
    output logic [kdcp_pkg::KEY_W-1:0]               o_key_mask,
    output logic                                     o_last_of_tick,
    input  wire logic                                i_cfg_we,
    input  wire logic [kdcp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [kdcp_pkg::KEY_W-1:0]          i_cfg_data
);

    import kdcp_pkg::*;

`include "key_debounce_click_press_detector_unit_defines.svh"

    // configuration
    logic [PERIOD_W-1:0] r_press_ticks;
    logic [PERIOD_W-1:0] r_double_ticks;
    logic [PERIOD_W-1:0] r_repeat_ticks;
    logic                r_press_en;
    logic                r_double_en;
    logic                r_repeat_en;

    // input register
    logic             r_in_vld;
    logic [KEY_W-1:0] r_in_raw;

    // debounce and timer state
    logic [KEY_W-1:0]      r_raw_hold;
    logic [KEY_W-1:0]      r_acc_now;
    logic                  r_run_taken;
    logic [KEY_W-1:0]      r_chg_mask;
    t_press_phase          r_phase;
    logic [TIMER_BITS-1:0] r_press_cnt;
    logic                  r_dbl_open;
    logic [TIMER_BITS-1:0] r_dbl_cnt;

    // event register
    t_event_kind           r_kind [MAX_EVENTS];
    logic [EV_CNT_W-1:0]   r_left;
    logic [KEY_W-1:0]      r_ev_mask;

    logic fire;
    logic pop;
    logic in_acc;

    logic [KEY_W-1:0] raw;
    logic             hit;
    logic             judge;
    logic [KEY_W-1:0] diff;
    logic             chg;
    logic             is_up;
    logic             is_down;

    logic                  dbl_ev;
    logic                  dbl_new;
    t_tick                 dbl_tick;
    logic                  n_dbl_open;
    logic [TIMER_BITS-1:0] n_dbl_cnt;

    t_press_phase          ph_mid;
    logic [TIMER_BITS-1:0] pc_mid;
    logic                  press_new;
    t_tick                 press_tick;
    t_press_phase          n_phase;
    logic [TIMER_BITS-1:0] n_press_cnt;
    logic                  push_ev;

    t_event_kind           n_kind [MAX_EVENTS];
    logic [EV_CNT_W-1:0]   n_left;

    // handshake
    assign o_out_valid = (r_left != '0);
    assign pop         = o_out_valid && !i_out_stall;
    assign fire        = r_in_vld &&
                         ((r_left == '0) || ((r_left == EV_CNT_W'(1)) && pop));
    assign o_in_stall  = r_in_vld && !fire;
    assign in_acc      = i_in_valid && !o_in_stall;

    assign o_event_kind   = r_kind[0];
    assign o_key_mask     = r_ev_mask;
    assign o_last_of_tick = (r_left == EV_CNT_W'(1));

    // debounce and scan event
    always_comb begin
        raw     = r_in_raw & KEY_MASK;
        hit     = (raw == r_raw_hold);
        judge   = hit && !r_run_taken;
        diff    = (r_acc_now ^ raw) & KEY_MASK;
        chg     = judge && (diff != '0);
        is_up   = chg && ((diff & raw) != '0);
        is_down = chg && !is_up;
    end

    // double window
    always_comb begin
        dbl_ev   = is_down && r_double_en && r_dbl_open;
        dbl_new  = is_down && r_double_en && !r_dbl_open;
        dbl_tick = tick_count(r_dbl_cnt, r_double_ticks);
        n_dbl_open = r_dbl_open;
        n_dbl_cnt  = r_dbl_cnt;
        if (dbl_ev || dbl_new) begin
            n_dbl_open = dbl_new;
            n_dbl_cnt  = '0;
        end else if (r_dbl_open) begin
            // count after the scan event; close on expiry
            if (dbl_tick.expired) begin
                n_dbl_open = 1'b0;
                n_dbl_cnt  = '0;
            end else begin
                n_dbl_cnt = dbl_tick.count;
            end
        end
    end

    // long-press next state
    always_comb begin
        ph_mid    = r_phase;
        pc_mid    = r_press_cnt;
        press_new = 1'b0;
        if (is_up) begin
            ph_mid = PH_IDLE;
            pc_mid = '0;
        end else if (is_down && r_press_en && (r_phase == PH_IDLE)) begin
            ph_mid    = PH_WAIT;
            pc_mid    = '0;
            press_new = 1'b1;
        end
        press_tick = tick_count(pc_mid,
                                (ph_mid == PH_REPEAT) ? r_repeat_ticks : r_press_ticks);
        n_phase     = ph_mid;
        n_press_cnt = pc_mid;
        case (ph_mid)
            PH_IDLE: begin
            end
            PH_WAIT: begin
                if (!press_new) begin
                    if (press_tick.expired) begin
                        n_press_cnt = '0;
                        n_phase     = r_repeat_en ? PH_REPEAT : PH_IDLE;
                    end else begin
                        n_press_cnt = press_tick.count;
                    end
                end
            end
            PH_REPEAT: begin
                n_press_cnt = press_tick.expired ? '0 : press_tick.count;
            end
            default: begin
                n_phase     = PH_IDLE;
                n_press_cnt = '0;
            end
        endcase
    end

    // long-press output
    always_comb begin
        case (ph_mid)
            PH_WAIT:   push_ev = !press_new && press_tick.expired;
            PH_REPEAT: push_ev = press_tick.expired;
            default:   push_ev = 1'b0;
        endcase
    end

    // pack events in order: scan, double, push
    always_comb begin
        n_kind = '{default: EV_UP};
        n_left = '0;
        if (chg) begin
            n_kind[0] = is_up ? EV_UP : EV_DOWN;
            n_left    = EV_CNT_W'(1);
        end
        if (dbl_ev) begin
            n_kind[n_left] = EV_DOUBLE;
            n_left         = n_left + EV_CNT_W'(1);
        end
        if (push_ev) begin
            n_kind[n_left] = EV_PUSH;
            n_left         = n_left + EV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_ticks  <= PRESS_TICKS_RST;
            r_double_ticks <= DOUBLE_TICKS_RST;
            r_repeat_ticks <= REPEAT_TICKS_RST;
            r_press_en     <= 1'b1;
            r_double_en    <= 1'b1;
            r_repeat_en    <= 1'b0;
            r_in_vld       <= 1'b0;
            r_raw_hold     <= '0;
            r_acc_now      <= IDLE_PATTERN_RST & KEY_MASK;
            r_run_taken    <= 1'b0;
            r_chg_mask     <= '0;
            r_phase        <= PH_IDLE;
            r_press_cnt    <= '0;
            r_dbl_open     <= 1'b0;
            r_dbl_cnt      <= '0;
            r_left         <= '0;
        end else begin
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (fire) begin
                r_in_vld <= 1'b0;
            end

            if (fire) begin
                if (!hit) begin
                    r_raw_hold  <= raw;
                    r_run_taken <= 1'b0;
                end else if (judge) begin
                    r_acc_now   <= raw;
                    r_run_taken <= 1'b1;
                    r_chg_mask  <= diff;
                end
                r_phase     <= n_phase;
                r_press_cnt <= n_press_cnt;
                r_dbl_open  <= n_dbl_open;
                r_dbl_cnt   <= n_dbl_cnt;
                r_left      <= n_left;
            end else if (pop) begin
                r_left <= r_left - EV_CNT_W'(1);
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_IDLE_PATTERN:  r_acc_now      <= i_cfg_data & KEY_MASK;
                    REG_PRESS_TICKS:   r_press_ticks  <= i_cfg_data[PERIOD_W-1:0];
                    REG_DOUBLE_TICKS:  r_double_ticks <= i_cfg_data[PERIOD_W-1:0];
                    REG_REPEAT_TICKS:  r_repeat_ticks <= i_cfg_data[PERIOD_W-1:0];
                    REG_PRESS_ENABLE:  r_press_en     <= i_cfg_data[0];
                    REG_DOUBLE_ENABLE: r_double_en    <= i_cfg_data[0];
                    REG_REPEAT_ENABLE: r_repeat_en    <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // event payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_raw <= i_raw_keys;
        end
        if (fire) begin
            r_kind    <= n_kind;
            r_ev_mask <= judge ? diff : r_chg_mask;
        end else if (pop) begin
            // advance to the next item of the tick
            r_kind[0] <= r_kind[1];
            r_kind[1] <= r_kind[2];
        end
    end

    `KDCP_ASSERT_NEXT(a_in_held, r_in_vld && !fire, r_in_vld && $stable(r_in_raw))
    `KDCP_ASSERT_NEXT(a_double_closes, fire && dbl_ev, !r_dbl_open && (r_dbl_cnt == '0))
    `KDCP_ASSERT_NEXT(a_drain_keeps, pop && (r_left > EV_CNT_W'(1)), o_out_valid)
    `KDCP_ASSERT_NOW(a_push_from_timer, fire && push_ev, (ph_mid == PH_WAIT) || (ph_mid == PH_REPEAT))

endmodule

`default_nettype wire
